>>> hw/rtl/gcms_pkg.sv
// shared constants, codes and control types of the gc mark-set engine
package gcms_pkg;

    // default sizes
    localparam int DEF_HEAP_WORDS    = 65536;
    localparam int DEF_GREY_DEPTH    = 1024;
    localparam int DEF_MAP_WORD_BITS = 64;

    // heap_words register value after reset
    localparam int HEAP_WORDS_RST = 65536;

    // field widths
    localparam int ACTION_W     = 3;
    localparam int ADDR_W       = 32;
    localparam int STATUS_W     = 4;
    localparam int OFFSET_W     = 16;
    localparam int HEAP_WORDS_W = 17;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 32;

    // stream data widths, padded to whole bytes
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 56;
    localparam int M_PAD_W   = M_TDATA_W - STATUS_W - ADDR_W - OFFSET_W;

    typedef logic [ACTION_W-1:0] t_action;
    typedef logic [STATUS_W-1:0] t_status;

    // action codes
    localparam t_action ACT_OFFER  = 3'd0;
    localparam t_action ACT_TAKE   = 3'd1;
    localparam t_action ACT_NEXT   = 3'd2;
    localparam t_action ACT_REWIND = 3'd3;
    localparam t_action ACT_CLEAR  = 3'd4;

    // result status codes
    localparam t_status ST_QUEUED    = 4'd0;
    localparam t_status ST_OFF_HEAP  = 4'd1;
    localparam t_status ST_ALREADY   = 4'd2;
    localparam t_status ST_FULL      = 4'd3;
    localparam t_status ST_TAKEN     = 4'd4;
    localparam t_status ST_EMPTY     = 4'd5;
    localparam t_status ST_FOUND     = 4'd6;
    localparam t_status ST_EXHAUSTED = 4'd7;
    localparam t_status ST_DONE      = 4'd8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_WORDS = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic    capture;     // latch offered address and heap offset
        logic    map_off;     // bitmap port addressed by offered word
        logic    map_set;     // write back word with mark bit set
        logic    fifo_push;   // queue latched address
        logic    grey_cap;    // hold head entry for the result
        logic    fifo_pop;    // retire head entry
        logic    scan_hit;    // record found offset, move scan past it
        logic    scan_adv;    // move scan to next word, read it
        logic    scan_rewind; // scan back to offset zero
        logic    clear_ptrs;  // empty queue, rewind scan, restart sweep
        logic    clr_step;    // zero one bitmap word
        logic    out_load;    // load result register
        t_status status;      // status for the result register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic on_heap;
        logic bit_set;
        logic fifo_full;
        logic fifo_empty;
        logic scan_end;
        logic scan_any;
        logic scan_last;
        logic clr_last;
        logic out_busy;
    } t_sts;

endpackage

>>> hw/rtl/gcms_ctrl.sv
// controller state machine of the gc mark-set engine
module gcms_ctrl import gcms_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    output logic    o_s_tready,
    input  t_action i_action,
    input  t_sts    i_sts,
    output t_cmd    o_cmd
);

    localparam logic [2:0] S_BOOT      = 3'd0;
    localparam logic [2:0] S_IDLE      = 3'd1;
    localparam logic [2:0] S_OFFER_CHK = 3'd2;
    localparam logic [2:0] S_OFFER_TST = 3'd3;
    localparam logic [2:0] S_TAKE      = 3'd4;
    localparam logic [2:0] S_SCAN      = 3'd5;
    localparam logic [2:0] S_CLR       = 3'd6;
    localparam logic [2:0] S_RESULT    = 3'd7;

    logic [2:0] r_state, n_state;
    t_status    r_status, n_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_BOOT;
            r_status <= ST_DONE;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);

    always_comb begin
        n_state      = r_state;
        n_status     = r_status;
        o_cmd        = '0;
        o_cmd.status = r_status;
        unique case (r_state)
            S_BOOT: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.capture = 1'b1;
                    unique case (i_action)
                        ACT_OFFER: n_state = S_OFFER_CHK;
                        ACT_TAKE: begin
                            if (i_sts.fifo_empty) begin
                                n_status = ST_EMPTY;
                                n_state  = S_RESULT;
                            end else begin
                                n_state = S_TAKE;
                            end
                        end
                        ACT_NEXT: begin
                            if (i_sts.scan_end) begin
                                n_status = ST_EXHAUSTED;
                                n_state  = S_RESULT;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        ACT_REWIND: begin
                            o_cmd.scan_rewind = 1'b1;
                            n_status = ST_DONE;
                            n_state  = S_RESULT;
                        end
                        ACT_CLEAR: begin
                            o_cmd.clear_ptrs = 1'b1;
                            n_state = S_CLR;
                        end
                        default: begin
                            n_status = ST_DONE;
                            n_state  = S_RESULT;
                        end
                    endcase
                end
            end
            S_OFFER_CHK: begin
                o_cmd.map_off = 1'b1;
                if (!i_sts.on_heap) begin
                    n_status = ST_OFF_HEAP;
                    n_state  = S_RESULT;
                end else begin
                    n_state = S_OFFER_TST;
                end
            end
            S_OFFER_TST: begin
                o_cmd.map_off = 1'b1;
                n_state = S_RESULT;
                priority if (i_sts.bit_set) begin
                    n_status = ST_ALREADY;
                end else if (i_sts.fifo_full) begin
                    n_status = ST_FULL;
                end else begin
                    o_cmd.map_set   = 1'b1;
                    o_cmd.fifo_push = 1'b1;
                    n_status = ST_QUEUED;
                end
            end
            S_TAKE: begin
                o_cmd.grey_cap = 1'b1;
                o_cmd.fifo_pop = 1'b1;
                n_status = ST_TAKEN;
                n_state  = S_RESULT;
            end
            S_SCAN: begin
                if (i_sts.scan_any) begin
                    o_cmd.scan_hit = 1'b1;
                    n_status = ST_FOUND;
                    n_state  = S_RESULT;
                end else begin
                    o_cmd.scan_adv = 1'b1;
                    if (i_sts.scan_last) begin
                        n_status = ST_EXHAUSTED;
                        n_state  = S_RESULT;
                    end
                end
            end
            S_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_status = ST_DONE;
                    n_state  = S_RESULT;
                end
            end
            S_RESULT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

>>> hw/rtl/gcms_dp.sv
// datapath of the gc mark-set engine: bitmap, grey queue, scan and result register
module gcms_dp import gcms_pkg::*; #(
    parameter int HEAP_WORDS    = DEF_HEAP_WORDS,
    parameter int GREY_DEPTH    = DEF_GREY_DEPTH,
    parameter int MAP_WORD_BITS = DEF_MAP_WORD_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [ADDR_W-1:0]     i_node_address,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    input  logic                  i_m_tready,
    output logic                  o_m_tvalid,
    output logic [M_TDATA_W-1:0]  o_m_tdata
);

    localparam int MAP_DEPTH = HEAP_WORDS / MAP_WORD_BITS;
    localparam int MAP_AW    = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
    localparam int SW_W      = MAP_AW + 1;
    localparam int BIT_W     = $clog2(MAP_WORD_BITS);
    localparam int OFF_W     = MAP_AW + BIT_W;
    localparam int LIM_MAX   = MAP_DEPTH * MAP_WORD_BITS;
    localparam int LIM_W     = $clog2(LIM_MAX + 1);
    localparam int LIM_RST   = (HEAP_WORDS_RST < LIM_MAX) ? HEAP_WORDS_RST : LIM_MAX;
    localparam int GREY_AW   = $clog2(GREY_DEPTH);
    localparam int CNT_W     = $clog2(GREY_DEPTH + 1);
    localparam int NGRP      = MAP_WORD_BITS / 8;
    localparam int GSEL_W    = BIT_W - 3;

    // configuration
    logic [ADDR_W-1:0]     r_heap_base;
    logic [LIM_W-1:0]      r_limit;
    logic [CFG_DATA_W-1:0] cfg_words;

    assign cfg_words = CFG_DATA_W'(i_cfg_data[HEAP_WORDS_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_base <= '0;
            r_limit     <= LIM_W'(LIM_RST);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_HEAP_BASE:  r_heap_base <= i_cfg_data[ADDR_W-1:0];
                CFG_HEAP_WORDS: begin
                    if (cfg_words > CFG_DATA_W'(LIM_MAX)) r_limit <= LIM_W'(LIM_MAX);
                    else r_limit <= cfg_words[LIM_W-1:0];
                end
                default: r_limit <= r_limit;
            endcase
        end
    end

    // offered pointer
    logic [ADDR_W-1:0] r_addr;
    logic [ADDR_W-1:0] r_off;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_addr <= i_node_address;
            r_off  <= i_node_address - r_heap_base;
        end
    end

    // bitmap memory, one port, read data registered
    logic [MAP_WORD_BITS-1:0] mem_map [MAP_DEPTH];
    logic [MAP_WORD_BITS-1:0] r_map_rd;
    logic [MAP_WORD_BITS-1:0] map_wd;
    logic [MAP_AW-1:0]        map_addr;
    logic                     map_we;
    logic [SW_W-1:0]          r_scan_word;
    logic [BIT_W-1:0]         r_scan_bit;
    logic [MAP_AW-1:0]        r_clr_addr;
    logic [MAP_AW-1:0]        off_word;
    logic [BIT_W-1:0]         off_bit;

    assign off_word = r_off[BIT_W +: MAP_AW];
    assign off_bit  = r_off[BIT_W-1:0];

    always_comb begin
        priority if (i_cmd.clr_step) map_addr = r_clr_addr;
        else if (i_cmd.map_off)      map_addr = off_word;
        else if (i_cmd.scan_adv)     map_addr = r_scan_word[MAP_AW-1:0] + 1'b1;
        else                         map_addr = r_scan_word[MAP_AW-1:0];
    end

    assign map_we = i_cmd.clr_step | i_cmd.map_set;
    assign map_wd = i_cmd.clr_step ? '0
                  : (r_map_rd | (MAP_WORD_BITS'(1) << off_bit));

    always_ff @(posedge i_clk) begin
        if (map_we) mem_map[map_addr] <= map_wd;
        r_map_rd <= mem_map[map_addr];
    end

    // clearing sweep
    logic clr_last;
    assign clr_last = (r_clr_addr == MAP_AW'(MAP_DEPTH - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear_ptrs) r_clr_addr <= '0;
        else if (i_cmd.clr_step) r_clr_addr <= clr_last ? '0 : r_clr_addr + 1'b1;
    end

    // grey queue
    logic [ADDR_W-1:0]  mem_grey [GREY_DEPTH];
    logic [ADDR_W-1:0]  r_grey_rd;
    logic [ADDR_W-1:0]  r_grey;
    logic [GREY_AW-1:0] r_head, r_tail;
    logic [CNT_W-1:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (i_cmd.fifo_push) mem_grey[r_tail] <= r_addr;
        r_grey_rd <= mem_grey[r_head];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.grey_cap) r_grey <= r_grey_rd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear_ptrs) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (i_cmd.fifo_push) begin
                r_tail  <= (r_tail == GREY_AW'(GREY_DEPTH - 1)) ? '0 : r_tail + 1'b1;
                r_count <= r_count + 1'b1;
            end else if (i_cmd.fifo_pop) begin
                r_head  <= (r_head == GREY_AW'(GREY_DEPTH - 1)) ? '0 : r_head + 1'b1;
                r_count <= r_count - 1'b1;
            end
        end
    end

    // scan: lowest set bit at or above the scan position
    logic [MAP_WORD_BITS-1:0] masked;
    logic [NGRP-1:0]          grp_nz;
    logic [2:0]               grp_idx [NGRP];
    logic [GSEL_W-1:0]        grp_sel;
    logic [BIT_W-1:0]         hit_bit;
    logic [OFF_W-1:0]         hit_off;
    logic [OFF_W+OFFSET_W-1:0] hit_ext;
    logic [OFFSET_W-1:0]      r_offset;

    assign masked = r_map_rd & ({MAP_WORD_BITS{1'b1}} << r_scan_bit);

    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            grp_nz[g]  = |masked[g*8 +: 8];
            grp_idx[g] = 3'd0;
            for (int k = 7; k >= 0; k--) begin
                if (masked[g*8 + k]) grp_idx[g] = 3'(k);
            end
        end
        grp_sel = '0;
        for (int g = NGRP - 1; g >= 0; g--) begin
            if (grp_nz[g]) grp_sel = GSEL_W'(g);
        end
    end

    assign hit_bit = {grp_sel, grp_idx[grp_sel]};
    assign hit_off = {r_scan_word[MAP_AW-1:0], hit_bit};
    assign hit_ext = {{OFFSET_W{1'b0}}, hit_off};

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_hit) r_offset <= hit_ext[OFFSET_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear_ptrs || i_cmd.scan_rewind) begin
            r_scan_word <= '0;
            r_scan_bit  <= '0;
        end else if (i_cmd.scan_hit) begin
            if (hit_bit == {BIT_W{1'b1}}) begin
                r_scan_word <= r_scan_word + 1'b1;
                r_scan_bit  <= '0;
            end else begin
                r_scan_bit <= hit_bit + 1'b1;
            end
        end else if (i_cmd.scan_adv) begin
            r_scan_word <= r_scan_word + 1'b1;
            r_scan_bit  <= '0;
        end
    end

    // result register
    logic                r_out_valid;
    t_status             r_out_status;
    logic [ADDR_W-1:0]   r_out_grey;
    logic [OFFSET_W-1:0] r_out_offset;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_valid <= 1'b0;
        else if (i_cmd.out_load) r_out_valid <= 1'b1;
        else if (i_m_tready) r_out_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_status <= i_cmd.status;
            r_out_grey   <= (i_cmd.status == ST_TAKEN) ? r_grey : '0;
            r_out_offset <= (i_cmd.status == ST_FOUND) ? r_offset : '0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{M_PAD_W{1'b0}}, r_out_offset, r_out_grey, r_out_status};

    // status to controller
    assign o_sts.on_heap    = (r_off < ADDR_W'(r_limit));
    assign o_sts.bit_set    = r_map_rd[off_bit];
    assign o_sts.fifo_full  = (r_count == CNT_W'(GREY_DEPTH));
    assign o_sts.fifo_empty = (r_count == '0);
    assign o_sts.scan_end   = (r_scan_word == SW_W'(MAP_DEPTH));
    assign o_sts.scan_any   = |grp_nz;
    assign o_sts.scan_last  = (r_scan_word == SW_W'(MAP_DEPTH - 1));
    assign o_sts.clr_last   = clr_last;
    assign o_sts.out_busy   = r_out_valid & ~i_m_tready;

endmodule

>>> hw/rtl/gc_mark_set_engine_core.sv
// top level of the gc mark-set engine: mark bitmap with grey work queue
//
// Mark-set unit of a garbage collector. Each input transfer carries one action and gives exactly
// one result transfer. An offered pointer outside the heap window (heap_base, heap_words clamped
// to the bitmap size, wrapping past the top of the address space) reports off heap; an on-heap
// pointer whose mark is already set reports already marked; otherwise its mark is set and the
// pointer queued, or, with the grey queue full, the mark stays clear and queue full is reported
// so the pointer can be offered again. Take grey returns the oldest queued pointer in order, or
// empty. Next marked walks the bitmap from the scan position, one bitmap word per cycle, and
// returns the word offset of the next mark (low 16 bits) or exhausted; the scan covers the whole
// bitmap and parks at its end until a rewind or clear. Clear all zeroes the bitmap, empties the
// queue and rewinds the scan.
// Steps per action, from accept to result ready, set by the single bitmap port: offer goes
// through offset, bitmap read, test and write-back and result load, with no test and write-back
// when off heap; take grey pops the queue head unless the queue is empty; rewind and unused
// codes go straight to result load; next marked visits bitmap words; clear all zeroes each word.
// One action is in flight at a time; a finished result waits in the output register while the
// next action is taken. After reset the bitmap is swept to zero, all HEAP_WORDS/MAP_WORD_BITS
// words (1024 by default), and no input is taken until it is done; configuration writes are taken at
// any time but must only be made while the unit is idle. MAP_WORD_BITS must be 32 or 64.
module gc_mark_set_engine_core import gcms_pkg::*; #(
    parameter int HEAP_WORDS    = DEF_HEAP_WORDS,
    parameter int GREY_DEPTH    = DEF_GREY_DEPTH,
    parameter int MAP_WORD_BITS = DEF_MAP_WORD_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input stream
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [S_TDATA_W-1:0]  i_s_tdata,   // action [2:0], node_address [34:3], zero pad
    // result stream
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [M_TDATA_W-1:0]  o_m_tdata,   // status [3:0], grey_address [35:4],
                                               // mark_offset [51:36], zero pad
    // configuration writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index, // 0 heap_base, 1 heap_words
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd    cmd;
    t_sts    sts;
    t_action s_action;

    // unpack the input transfer
    assign s_action = i_s_tdata[ACTION_W-1:0];

    // configuration registers accept every transfer
    assign o_cfg_ready = 1'b1;

    gcms_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_action   (s_action),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    gcms_dp #(
        .HEAP_WORDS    (HEAP_WORDS),
        .GREY_DEPTH    (GREY_DEPTH),
        .MAP_WORD_BITS (MAP_WORD_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_node_address (i_s_tdata[ACTION_W +: ADDR_W]),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_m_tready     (i_m_tready),
        .o_m_tvalid     (o_m_tvalid),
        .o_m_tdata      (o_m_tdata)
    );

    // a queue is never full and empty at once
    a_fifo_levels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(sts.fifo_full && sts.fifo_empty))
        else $error("grey queue full and empty together");

    // no push into a full queue, no pop from an empty one
    a_fifo_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.fifo_push |-> !sts.fifo_full)
        else $error("push into full grey queue");

    a_fifo_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.fifo_pop |-> !sts.fifo_empty)
        else $error("pop from empty grey queue");

    // a new result never overwrites one that is still stalled
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> !sts.out_busy)
        else $error("result register overwritten while stalled");

    // no input is taken while the bitmap is being swept
    a_sweep_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.clr_step |-> !o_s_tready)
        else $error("input ready during bitmap sweep");

endmodule
